/* rtl/pae_pkg.sv */
// Shared types and constants for the polynomial arithmetic engine.
package pae_pkg;

  localparam int COEFF_W   = 32;
  localparam int POWER_W   = 5;
  localparam int OUT_CAP   = 31;
  localparam int CFG_IDX_W = 1;
  localparam int IN_W      = 64;
  localparam int OUT_W     = 40;

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_SCL  = 3'd3;
  localparam logic [2:0] MODE_ADDS = 3'd4;
  localparam logic [2:0] MODE_SUBS = 3'd5;
  localparam logic [2:0] MODE_CMP  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALAR  = 1'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } state_t;

endpackage

/* rtl/pae_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/polynomial_arithmetic_engine.sv */
// Polynomial arithmetic engine: load two polynomials, then stream the selected result.
//
// Input stream: one coefficient pair per transfer, lowest power first; tlast marks
// the highest power and starts the computation. Pairs past MAX_TERMS are dropped
// and reported through the overflow bit of every result of that run.
// Output stream: one transfer per result coefficient, power 0 upward, at most 31;
// tlast marks the final result. Compare mode gives one transfer with the verdict.
// Config channel: index 0 writes op_mode, index 1 writes scalar; always ready.
// Timing: the input is ready while pairs are loaded. After the last pair the input is not
// ready until the run's final result is taken. Each result runs its
// multiply-accumulate terms through the single shared multiplier/adder: one term for
// the element-wise modes, up to L terms in multiply, and L terms for compare (L = stored terms).
// A stalled receiver holds the result in the output register; the sequencer waits.
// Reset (synchronous, rst high) clears the mode, scalar, term count and drop flag;
// coefficient storage is not cleared, only entries written in the current run are read.
module polynomial_arithmetic_engine #(
  parameter int MAX_TERMS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pae_pkg::IN_W-1:0]       s_axis_tdata,   // coeff_a[31:0], coeff_b[63:32]
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pae_pkg::OUT_W-1:0]      m_axis_tdata,   // coeff[31:0], power[36:32],
                                                         // equal[37], overflow[38], pad[39]
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pae_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pae_pkg::COEFF_W-1:0]    cfg_data
);
  import pae_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);
  localparam int CW = $clog2(MAX_TERMS + 1);

  state_t state, state_next;

  logic [2:0]         op_mode;
  logic [COEFF_W-1:0] scalar;
  logic [CW-1:0]      term_count;
  logic               dropped_flag;
  logic [CW-1:0]      len;
  logic               ovf;
  logic [POWER_W-1:0] n_res;
  logic [POWER_W-1:0] k;
  logic [AW-1:0]      i;
  logic [AW-1:0]      hi;
  logic               v1, last1, v2, last2;
  logic [COEFF_W-1:0] prod;
  logic [COEFF_W-1:0] acc;
  logic               neq;
  logic [COEFF_W-1:0] coeff_out;
  logic [POWER_W-1:0] power_out;
  logic               eq_out;
  logic               eor_out;

  logic               in_xfer, out_xfer, room;
  logic [CW-1:0]      len_new;
  logic [7:0]         total8, k8, len8, lo8, hi8;
  logic [AW-1:0]      rd_addr_a, rd_addr_b;
  logic [COEFF_W-1:0] a_q, b_q, mul_b, mul_q, op_res;
  logic               is_cmp;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign room     = term_count < CW'(MAX_TERMS);
  assign len_new  = room ? term_count + CW'(1) : term_count;
  assign total8   = (op_mode == MODE_MUL) ? (8'(len_new) << 1) - 8'd1 : 8'(len_new);
  assign is_cmp   = op_mode == MODE_CMP;

  // Summation bounds for result k
  assign k8   = 8'(k);
  assign len8 = 8'(len);
  always_comb begin
    lo8 = 8'(k);
    hi8 = 8'(k);
    if (op_mode == MODE_MUL) begin
      lo8 = (k8 >= len8) ? k8 - len8 + 8'd1 : 8'd0;
      hi8 = (k8 < len8) ? k8 : len8 - 8'd1;
    end else if (is_cmp) begin
      lo8 = 8'd0;
      hi8 = len8 - 8'd1;
    end
  end

  assign rd_addr_a = i;
  assign rd_addr_b = (op_mode == MODE_MUL) ? AW'(k8 - 8'(i)) : i;

  pae_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_TERMS)) u_ram_a (
    .clk     (clk),
    .wr_en   (in_xfer && room),
    .wr_addr (term_count[AW-1:0]),
    .wr_data (s_axis_tdata[COEFF_W-1:0]),
    .rd_addr (rd_addr_a),
    .rd_data (a_q)
  );

  pae_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_TERMS)) u_ram_b (
    .clk     (clk),
    .wr_en   (in_xfer && room),
    .wr_addr (term_count[AW-1:0]),
    .wr_data (s_axis_tdata[IN_W-1:COEFF_W]),
    .rd_addr (rd_addr_b),
    .rd_data (b_q)
  );

  // Shared multiplier and adder
  assign mul_b = (op_mode == MODE_MUL) ? b_q : scalar;
  assign mul_q = COEFF_W'(a_q * mul_b);

  always_comb begin
    unique case (op_mode)
      MODE_SUB:  op_res = a_q - b_q;
      MODE_MUL:  op_res = mul_q;
      MODE_SCL:  op_res = mul_q;
      MODE_ADDS: op_res = (k == '0) ? a_q + scalar : a_q;
      MODE_SUBS: op_res = (k == '0) ? a_q - scalar : a_q;
      MODE_CMP:  op_res = '0;
      default:   op_res = a_q + b_q;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (in_xfer && s_axis_tlast) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_ISSUE;
      ST_ISSUE: if (i == hi) state_next = ST_DRAIN;
      ST_DRAIN: if (v2 && last2) state_next = ST_OUT;
      ST_OUT: begin
        if (out_xfer) state_next = eor_out ? ST_LOAD : ST_SETUP;
      end
      default:  state_next = ST_LOAD;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready = state == ST_LOAD;
    m_axis_tvalid = state == ST_OUT;
    cfg_ready     = 1'b1;
  end

  assign m_axis_tdata = {1'b0, ovf, eq_out, power_out, coeff_out};
  assign m_axis_tlast = eor_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      op_mode      <= MODE_ADD;
      scalar       <= '0;
      term_count   <= '0;
      dropped_flag <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_OP_MODE: op_mode <= cfg_data[2:0];
          REG_SCALAR:  scalar  <= cfg_data;
          default:     ;
        endcase
      end

      if (in_xfer) begin
        if (s_axis_tlast) begin
          term_count   <= '0;
          dropped_flag <= 1'b0;
        end else begin
          term_count   <= len_new;
          dropped_flag <= dropped_flag | !room;
        end
      end

      v1 <= state == ST_ISSUE;
      v2 <= v1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_xfer && s_axis_tlast) begin
      len   <= len_new;
      // compare gives a single result, so only dropped pairs count there
      ovf   <= dropped_flag | !room | (!is_cmp && (total8 > 8'(OUT_CAP)));
      n_res <= (total8 > 8'(OUT_CAP)) ? POWER_W'(OUT_CAP) : POWER_W'(total8);
      k     <= '0;
    end

    if (state == ST_SETUP) begin
      hi  <= AW'(hi8);
      i   <= AW'(lo8);
      acc <= '0;
      neq <= 1'b0;
    end

    if (state == ST_ISSUE && i != hi) begin
      i <= i + AW'(1);
    end
    last1 <= (state == ST_ISSUE) && (i == hi);

    if (v1) begin
      prod <= op_res;
      if (a_q != b_q) neq <= 1'b1;
    end
    last2 <= last1;

    if (v2) begin
      acc <= acc + prod;
      if (last2) begin
        coeff_out <= is_cmp ? '0 : acc + prod;
        power_out <= is_cmp ? '0 : k;
        eq_out    <= is_cmp && !neq;
        eor_out   <= is_cmp || (k + POWER_W'(1) == n_res);
      end
    end

    if (state == ST_OUT && out_xfer && !eor_out) begin
      k <= k + POWER_W'(1);
    end
  end

endmodule

/* tb/polynomial_arithmetic_engine_test.sv */
// Self-checking testbench: streams coefficient runs in all op modes, predicts every result term.
module polynomial_arithmetic_engine_test;
  import pae_pkg::*;

  localparam int MAX_TERMS = 16;
  localparam logic [2:0] MODE_SPARE = 3'd7;  // unused code, decodes as add
  localparam int RANDOM_PAIRS = 120;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic               last;
    logic [COEFF_W-1:0] b;
    logic [COEFF_W-1:0] a;
  } pair_t;

  typedef struct packed {
    logic               eor;
    logic               ovf;
    logic               equal;
    logic [POWER_W-1:0] power;
    logic [COEFF_W-1:0] coeff;
  } term_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;   // coeff_a[31:0], coeff_b[63:32]
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;        // coeff[31:0], power[36:32], equal[37], overflow[38]
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEFF_W-1:0]   cfg_data = '0;

  polynomial_arithmetic_engine #(.MAX_TERMS(MAX_TERMS)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  pair_t pair_q[$];   // pairs waiting to be sent
  term_t term_q[$];   // result terms still due from the block

  // Predictor copy of the block state and registers
  logic [COEFF_W-1:0] held_a[MAX_TERMS];
  logic [COEFF_W-1:0] held_b[MAX_TERMS];
  int                 held_cnt = 0;
  logic               held_drop = 1'b0;
  logic [2:0]         cur_mode = MODE_ADD;
  logic [COEFF_W-1:0] cur_scalar = '0;

  int    errors = 0;
  int    results_seen = 0;
  int    pairs_queued = 0;
  int    src_gap = 0;
  int    sink_gap = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;
  int    quiet_cycles = 0;
  logic  idle_en = 1'b1;
  pair_t next_pair;
  term_t got_term;

  task automatic apply_poly_op(input pair_t p);
    int                 len;
    int                 n;
    logic               ovf;
    logic               same;
    logic [COEFF_W-1:0] c;
    term_t              t;
    if (held_cnt < MAX_TERMS) begin
      held_a[held_cnt] = p.a;
      held_b[held_cnt] = p.b;
      held_cnt++;
    end else begin
      held_drop = 1'b1;
    end
    if (!p.last) return;
    len = held_cnt;
    ovf = held_drop;
    held_cnt = 0;
    held_drop = 1'b0;
    if (cur_mode == MODE_CMP) begin
      same = 1'b1;
      for (int i = 0; i < len; i++)
        if (held_a[i] != held_b[i]) same = 1'b0;
      t = '0;
      t.equal = same;
      t.ovf = ovf;
      t.eor = 1'b1;
      term_q.push_back(t);
      return;
    end
    n = (cur_mode == MODE_MUL) ? 2 * len - 1 : len;
    if (n > OUT_CAP) begin
      n = OUT_CAP;
      ovf = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      case (cur_mode)
        MODE_SUB: c = held_a[k] - held_b[k];
        MODE_MUL: begin
          c = '0;
          for (int i = 0; i < len && i <= k; i++)
            if (k - i < len) c += held_a[i] * held_b[k - i];
        end
        MODE_SCL:  c = held_a[k] * cur_scalar;
        MODE_ADDS: c = (k == 0) ? held_a[k] + cur_scalar : held_a[k];
        MODE_SUBS: c = (k == 0) ? held_a[k] - cur_scalar : held_a[k];
        default:   c = held_a[k] + held_b[k];
      endcase
      t.coeff = c;
      t.power = POWER_W'(k);
      t.equal = 1'b0;
      t.ovf = ovf;
      t.eor = (k + 1 == n);
      term_q.push_back(t);
    end
  endtask

  function automatic void note_mismatch(string what, term_t want, term_t got);
    errors++;
    if (errors <= 10)
      $display({"%0t mismatch (%s): exp coeff=%h power=%0d eq=%b ovf=%b last=%b",
                " | got coeff=%h power=%0d eq=%b ovf=%b last=%b"},
               $realtime, what, want.coeff, want.power, want.equal, want.ovf, want.eor,
               got.coeff, got.power, got.equal, got.ovf, got.eor);
  endfunction

  // Sender: one pair per transfer, random idle bursts between pairs
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        apply_poly_op({s_axis_tlast, s_axis_tdata[63:32], s_axis_tdata[31:0]});
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pair_q.size() > 0) begin
          next_pair = pair_q.pop_front();
          s_axis_tdata <= {next_pair.b, next_pair.a};
          s_axis_tlast <= next_pair.last;
          s_axis_tvalid <= 1'b1;
          if (idle_en && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 17);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer, stalls in bursts, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_term.coeff = m_axis_tdata[31:0];
        got_term.power = m_axis_tdata[36:32];
        got_term.equal = m_axis_tdata[37];
        got_term.ovf = m_axis_tdata[38];
        got_term.eor = m_axis_tlast;
        results_seen++;
        if (term_q.size() == 0) note_mismatch("no result due", '0, got_term);
        else if (term_q[0] != got_term) note_mismatch("result", term_q.pop_front(), got_term);
        else void'(term_q.pop_front());
      end
      // long hold-off only while the sender still has pairs to offer
      if (!hold_done && results_seen >= 40 && (pair_q.size() > 0 || s_axis_tvalid)) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 17);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** polynomial_arithmetic_engine: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == REG_OP_MODE) cur_mode = val[2:0];
    else cur_scalar = val;
    cfg_valid <= 1'b0;
  endtask

  // Block is idle once all pairs went out and every due term came back
  task automatic wait_idle();
    do @(posedge clk); while (pair_q.size() != 0 || s_axis_tvalid || term_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] mode, input logic [COEFF_W-1:0] scal);
    wait_idle();
    write_reg(REG_OP_MODE, {29'd0, mode});
    write_reg(REG_SCALAR, scal);
  endtask

  task automatic push_pair(input logic [COEFF_W-1:0] a, input logic [COEFF_W-1:0] b,
                           input logic last);
    pair_q.push_back({last, b, a});
    pairs_queued++;
  endtask

  function automatic logic [COEFF_W-1:0] rand_coeff();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'hffff_ffff;
      3:       return '0;
      4, 5:    return $urandom_range(0, 7) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 5);
    if (r < 17) return $urandom_range(6, 15);
    if (r == 17) return MAX_TERMS;
    return $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4);
  endfunction

  // Twin runs (B copies A, maybe one flipped bit) drive the compare path both ways
  task automatic queue_run(input int len);
    bit                 twin;
    int                 flip_at;
    logic [COEFF_W-1:0] a;
    logic [COEFF_W-1:0] b;
    twin = (cur_mode == MODE_CMP) || ($urandom_range(0, 4) == 0);
    flip_at = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      a = rand_coeff();
      b = twin ? a : rand_coeff();
      if (twin && i == flip_at) b = a ^ (32'd1 << $urandom_range(0, 31));
      push_pair(a, b, i == len - 1);
    end
  endtask

  initial begin
    int                 ph;
    int                 base;
    logic [2:0]         mode;
    logic [COEFF_W-1:0] scal;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes and wraparound in every mode
    configure(MODE_ADD, '0);
    push_pair(32'h7fff_ffff, 32'h0000_0001, 1'b1);
    push_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
    push_pair(32'hffff_ffff, 32'hffff_ffff, 1'b1);
    configure(MODE_SUB, 32'hffff_ffff);
    push_pair(32'h8000_0000, 32'h0000_0001, 1'b0);
    push_pair(32'h0000_0000, 32'h7fff_ffff, 1'b1);
    configure(MODE_MUL, '0);
    push_pair(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    push_pair(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    push_pair(32'h8000_0000, 32'h7fff_ffff, 1'b1);
    push_pair(32'h8000_0000, 32'hffff_ffff, 1'b1);
    configure(MODE_SCL, 32'h8000_0000);
    push_pair(32'hffff_ffff, 32'h1234_5678, 1'b0);
    push_pair(32'h0000_0003, 32'h0000_0000, 1'b1);
    configure(MODE_ADDS, 32'h7fff_ffff);
    push_pair(32'h0000_0001, 32'hdead_beef, 1'b0);
    push_pair(32'h0000_0005, 32'h0000_0000, 1'b1);
    configure(MODE_SUBS, 32'h8000_0000);
    push_pair(32'h0000_0000, 32'hffff_ffff, 1'b1);
    configure(MODE_CMP, '0);
    push_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
    push_pair(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    push_pair(32'h0000_0005, 32'h0000_0005, 1'b0);
    push_pair(32'h8000_0000, 32'h0000_0000, 1'b1);
    push_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
    configure(MODE_SPARE, 32'h7fff_ffff);
    push_pair(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);

    // Random phases: first eight walk all mode codes, with full and overlong runs
    base = pairs_queued;
    ph = 0;
    while (pairs_queued - base < RANDOM_PAIRS) begin
      mode = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0:       scal = 32'h7fff_ffff;
        1:       scal = 32'h8000_0000;
        2:       scal = '0;
        3:       scal = 32'hffff_ffff;
        default: scal = $urandom;
      endcase
      if (pairs_queued - base > RANDOM_PAIRS - 30) idle_en <= 1'b0;
      configure(mode, scal);
      if (ph < 8 && ph % 2 == 0) queue_run(MAX_TERMS + ph / 4);
      repeat ($urandom_range(1, 4)) queue_run(pick_len());
      ph++;
    end

    wait_idle();
    if (errors == 0 && term_q.size() == 0)
      $display("** polynomial_arithmetic_engine: PASSED **");
    else
      $display("** polynomial_arithmetic_engine: FAILED **");
    $finish;
  end

endmodule

/* polynomial_arithmetic_engine.f */
rtl/pae_pkg.sv
rtl/pae_ram.sv
rtl/polynomial_arithmetic_engine.sv
tb/polynomial_arithmetic_engine_test.sv
